### src/lrf_pkg.sv
`timescale 1ns / 1ps

package lrf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SUM_W      = DATA_WIDTH + CNT_W;
  localparam int SXX_W      = 2 * DATA_WIDTH - 2 + CNT_W;
  localparam int SXY_W      = 2 * DATA_WIDTH - 1 + CNT_W;

  // shared arithmetic word
  localparam int WORD_W = 128;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    logic    sgn;
  } alu_ctl_t;

endpackage

### src/lrf_alu.sv
`timescale 1ns / 1ps

// Shared multi-cycle unit. MUL: a times signed b, shift-add over the bits of |b|.
// DIV: a over unsigned b, restoring one bit a cycle, rounded half up; with sgn
// the numerator is signed and the quotient rounds half away from zero.
module lrf_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  lrf_pkg::alu_ctl_t ctl,
  input  lrf_pkg::word_t    a_i,
  input  lrf_pkg::word_t    b_i,
  output logic              done_o,
  output lrf_pkg::word_t    res_o
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_MUL,
    P_DIV,
    P_RND,
    P_FIN
  } phase_t;

  localparam int CW = $clog2(lrf_pkg::WORD_W);

  phase_t              phase_r;
  lrf_pkg::word_t      acc_r;
  lrf_pkg::word_t      ma_r;
  lrf_pkg::word_t      mb_r;
  logic [lrf_pkg::WORD_W:0] rem_r;
  logic                neg_r;
  logic [CW-1:0]       cnt_r;
  logic                done_r;

  lrf_pkg::word_t           b_abs;
  lrf_pkg::word_t           a_abs;
  logic [lrf_pkg::WORD_W:0] rem_sh;
  logic [lrf_pkg::WORD_W:0] dvs;
  logic                     ge;
  logic                     rnd_ge;

  assign b_abs  = b_i[lrf_pkg::WORD_W-1] ? (~b_i + 1'b1) : b_i;
  assign a_abs  = (ctl.sgn && a_i[lrf_pkg::WORD_W-1]) ? (~a_i + 1'b1) : a_i;
  assign dvs    = {1'b0, ma_r};
  assign rem_sh = {rem_r[lrf_pkg::WORD_W-1:0], mb_r[lrf_pkg::WORD_W-1]};
  assign ge     = (rem_sh >= dvs);
  assign rnd_ge = ({rem_r[lrf_pkg::WORD_W-1:0], 1'b0} >= dvs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        P_IDLE: begin
          if (ctl.start) begin
            acc_r <= '0;
            if (ctl.op == lrf_pkg::ALU_MUL) begin
              ma_r    <= a_i;
              mb_r    <= b_abs;
              neg_r   <= b_i[lrf_pkg::WORD_W-1];
              phase_r <= P_MUL;
            end else begin
              ma_r  <= b_i;
              mb_r  <= a_abs;
              rem_r <= '0;
              cnt_r <= '0;
              neg_r <= ctl.sgn & a_i[lrf_pkg::WORD_W-1];
              if (b_i == '0) begin
                acc_r   <= '1;
                phase_r <= P_FIN;
              end else begin
                phase_r <= P_DIV;
              end
            end
          end
        end
        P_MUL: begin
          if (mb_r == '0) begin
            phase_r <= P_FIN;
          end else begin
            if (mb_r[0]) acc_r <= acc_r + ma_r;
            ma_r <= ma_r << 1;
            mb_r <= mb_r >> 1;
          end
        end
        P_DIV: begin
          rem_r <= ge ? (rem_sh - dvs) : rem_sh;
          acc_r <= {acc_r[lrf_pkg::WORD_W-2:0], ge};
          mb_r  <= mb_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) phase_r <= P_RND;
        end
        P_RND: begin
          acc_r   <= acc_r + lrf_pkg::word_t'(rnd_ge);
          phase_r <= P_FIN;
        end
        P_FIN: begin
          acc_r   <= neg_r ? (~acc_r + 1'b1) : acc_r;
          done_r  <= 1'b1;
          phase_r <= P_IDLE;
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign done_o = done_r;
  assign res_o  = acc_r;

endmodule

### src/linear_regression_fit_with_error_metrics.sv
`timescale 1ns / 1ps

// Least-squares line fit over a set of signed (x,y) points with error metrics.
// Input stream: one point per word, taken whenever valid while loading. tlast on
// a point closes the set; in_tready then drops for the whole fit.
// The fit runs on one shared shift-add multiplier / restoring divider: five
// multiplies and two divides for the line, then per stored point up to four
// multiplies (each running over the bits of the magnitude of its second
// operand) plus bookkeeping steps, then three divides and two multiplies.
// Points past the store depth are dropped and reported in tuser.
// Result stream: one word per set, held in an output register until taken; the
// next set loads while it waits, and a second fit holds until the slot frees.
// Reset empties the set and the output slot; the store needs no clearing.
module linear_regression_fit_with_error_metrics (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // x_value[15:0], y_value[31:16]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // slope[47:0], intercept[95:48], abs_error_sum[158:96], mean_abs_error[205:159],
  // mean_sq_error[268:206], r_squared[316:269], point_count[327:317]
  output logic [327:0] out_tdata,
  output logic [2:0]   out_tuser   // x_constant[0], y_constant[1], overflowed[2]
);

  localparam int AW   = lrf_pkg::ADDR_W;
  localparam int CW   = lrf_pkg::CNT_W;
  localparam int SW   = lrf_pkg::SUM_W;
  localparam int DW   = lrf_pkg::DATA_WIDTH;
  localparam int E_W  = 65;
  localparam int AB_W = 76;
  localparam int SE_W = 108;
  localparam int ST_W = 64;
  localparam int PC_W = 11;

  localparam lrf_pkg::word_t SSE_CAP = lrf_pkg::word_t'(1) << 107;
  localparam lrf_pkg::word_t S48_MIN = {{81{1'b1}}, 47'd0};
  localparam lrf_pkg::word_t S48_MAX = {81'd0, {47{1'b1}}};
  localparam lrf_pkg::word_t U47_MAX = {81'd0, {47{1'b1}}};
  localparam lrf_pkg::word_t U63_MAX = {65'd0, {63{1'b1}}};
  localparam lrf_pkg::word_t ONE_Q   = lrf_pkg::word_t'(65536);
  localparam lrf_pkg::word_t R2_LIM  = ONE_Q + (lrf_pkg::word_t'(1) << 47);

  typedef enum logic [4:0] {
    S_LOAD, S_NXX, S_SXX, S_NXY, S_SXY, S_SLOPE, S_SLSX, S_ICPT,
    S_PRD, S_PMUL, S_PABS, S_PACC, S_PSQ, S_PNY, S_PDV,
    S_MAE, S_MSE, S_RN1, S_RN2, S_RDIV, S_DONE
  } state_t;

  function automatic logic [47:0] sat48(input lrf_pkg::word_t v);
    logic [47:0] r;
    if ($signed(v) < $signed(S48_MIN)) r = S48_MIN[47:0];
    else if ($signed(v) > $signed(S48_MAX)) r = S48_MAX[47:0];
    else r = v[47:0];
    return r;
  endfunction

  state_t                 state_r;
  logic                   wait_r;
  logic [CW-1:0]          n_r;
  logic signed [SW-1:0]   sx_r;
  logic signed [SW-1:0]   sy_r;
  logic signed [lrf_pkg::SXX_W-1:0] sxx_r;
  logic signed [lrf_pkg::SXY_W-1:0] sxy_r;
  logic                   ovf_r;

  lrf_pkg::word_t         t0_r;
  lrf_pkg::word_t         t1_r;
  lrf_pkg::word_t         d_r;
  logic signed [47:0]     slope_r;
  logic signed [47:0]     icpt_r;
  logic [E_W-1:0]         e_r;
  logic [AB_W-1:0]        abs_r;
  logic [SE_W-1:0]        sse_r;
  logic [ST_W-1:0]        sst_r;
  logic [CW-1:0]          i_r;
  logic                   xc_r;
  logic                   yc_r;
  logic [46:0]            mae_r;
  logic [62:0]            mse_r;
  logic [47:0]            r2_r;

  logic                   out_valid_r;
  logic [327:0]           out_tdata_r;
  logic [2:0]             out_tuser_r;

  logic [31:0]            mem [lrf_pkg::MAX_POINTS];
  logic [31:0]            rd_r;

  lrf_pkg::alu_ctl_t      alu_ctl;
  lrf_pkg::word_t         alu_a;
  lrf_pkg::word_t         alu_b;
  logic                   alu_done;
  lrf_pkg::word_t         alu_res;

  logic                   in_fire;
  logic                   room;
  logic signed [DW-1:0]   x_v;
  logic signed [DW-1:0]   y_v;
  logic signed [DW-1:0]   px;
  logic signed [DW-1:0]   py;
  logic                   op_state;
  lrf_pkg::word_t         sse_sum;
  logic [CW-1:0]          i_nxt;
  logic [62:0]            abs63;
  logic                   out_load;

  assign in_tready = (state_r == S_LOAD);
  assign in_fire   = in_tvalid & in_tready;
  assign room      = (n_r < CW'(lrf_pkg::MAX_POINTS));
  assign x_v       = in_tdata[DW-1:0];
  assign y_v       = in_tdata[16+DW-1:16];
  assign px        = rd_r[DW-1:0];
  assign py        = rd_r[16+DW-1:16];
  assign sse_sum   = lrf_pkg::word_t'(sse_r) + alu_res;
  assign i_nxt     = i_r + CW'(1);
  assign abs63     = (abs_r > AB_W'(U63_MAX)) ? U63_MAX[62:0] : abs_r[62:0];
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // point store: write while loading, read one entry per pass step
  always_ff @(posedge clk) begin
    if (in_fire && room) mem[n_r[AW-1:0]] <= in_tdata;
    rd_r <= mem[i_r[AW-1:0]];
  end

  always_comb begin
    op_state = 1'b1;
    alu_a    = '0;
    alu_b    = '0;
    alu_ctl.op  = lrf_pkg::ALU_MUL;
    alu_ctl.sgn = 1'b0;
    unique case (state_r)
      S_NXX:   begin alu_a = lrf_pkg::word_t'(sxx_r); alu_b = lrf_pkg::word_t'(n_r); end
      S_SXX:   begin alu_a = lrf_pkg::word_t'(sx_r);  alu_b = lrf_pkg::word_t'(sx_r); end
      S_NXY:   begin alu_a = lrf_pkg::word_t'(sxy_r); alu_b = lrf_pkg::word_t'(n_r); end
      S_SXY:   begin alu_a = lrf_pkg::word_t'(sx_r);  alu_b = lrf_pkg::word_t'(sy_r); end
      S_SLOPE: begin
        alu_ctl.op  = lrf_pkg::ALU_DIV;
        alu_ctl.sgn = 1'b1;
        alu_a = t0_r << 16;
        alu_b = d_r;
      end
      S_SLSX:  begin alu_a = lrf_pkg::word_t'(slope_r); alu_b = lrf_pkg::word_t'(sx_r); end
      S_ICPT:  begin
        alu_ctl.op  = lrf_pkg::ALU_DIV;
        alu_ctl.sgn = 1'b1;
        alu_a = (lrf_pkg::word_t'(sy_r) << 16) - t1_r;
        alu_b = lrf_pkg::word_t'(n_r);
      end
      S_PMUL:  begin alu_a = lrf_pkg::word_t'(slope_r); alu_b = lrf_pkg::word_t'(px); end
      S_PSQ:   begin alu_a = lrf_pkg::word_t'(e_r); alu_b = lrf_pkg::word_t'(e_r); end
      S_PNY:   begin alu_a = lrf_pkg::word_t'(py); alu_b = lrf_pkg::word_t'(n_r); end
      S_PDV:   begin alu_a = t1_r; alu_b = t1_r; end
      S_MAE:   begin
        alu_ctl.op = lrf_pkg::ALU_DIV;
        alu_a = lrf_pkg::word_t'(abs_r);
        alu_b = lrf_pkg::word_t'(n_r);
      end
      S_MSE:   begin
        alu_ctl.op = lrf_pkg::ALU_DIV;
        alu_a = lrf_pkg::word_t'(sse_r);
        alu_b = lrf_pkg::word_t'(n_r) << 16;
      end
      S_RN1:   begin alu_a = lrf_pkg::word_t'(sse_r); alu_b = lrf_pkg::word_t'(n_r); end
      S_RN2:   begin alu_a = t0_r; alu_b = lrf_pkg::word_t'(n_r); end
      S_RDIV:  begin
        alu_ctl.op = lrf_pkg::ALU_DIV;
        alu_a = t0_r;
        alu_b = lrf_pkg::word_t'(sst_r) << 16;
      end
      default: op_state = 1'b0;
    endcase
    alu_ctl.start = op_state & ~wait_r;
  end

  lrf_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      wait_r      <= 1'b0;
      n_r         <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load | (out_valid_r & ~out_tready);
      if (alu_ctl.start) wait_r <= 1'b1;
      if (alu_done) wait_r <= 1'b0;

      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (room) begin
              n_r   <= n_r + CW'(1);
              sx_r  <= sx_r + SW'(x_v);
              sy_r  <= sy_r + SW'(y_v);
              sxx_r <= sxx_r + (lrf_pkg::SXX_W'(x_v) * lrf_pkg::SXX_W'(x_v));
              sxy_r <= sxy_r + (lrf_pkg::SXY_W'(x_v) * lrf_pkg::SXY_W'(y_v));
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) state_r <= S_NXX;
          end
        end
        S_NXX: if (alu_done) begin t0_r <= alu_res; state_r <= S_SXX; end
        S_SXX: if (alu_done) begin d_r <= t0_r - alu_res; state_r <= S_NXY; end
        S_NXY: if (alu_done) begin t0_r <= alu_res; state_r <= S_SXY; end
        S_SXY: begin
          if (alu_done) begin
            t0_r  <= t0_r - alu_res;
            xc_r  <= (d_r == '0);
            i_r   <= '0;
            abs_r <= '0;
            sse_r <= '0;
            sst_r <= '0;
            if (d_r == '0) begin
              slope_r <= '0;
              icpt_r  <= '0;
              state_r <= (n_r == '0) ? S_MAE : S_PRD;
            end else begin
              state_r <= S_SLOPE;
            end
          end
        end
        S_SLOPE: if (alu_done) begin slope_r <= sat48(alu_res); state_r <= S_SLSX; end
        S_SLSX:  if (alu_done) begin t1_r <= alu_res; state_r <= S_ICPT; end
        S_ICPT: begin
          if (alu_done) begin
            icpt_r  <= sat48(alu_res);
            state_r <= S_PRD;
          end
        end
        S_PRD: state_r <= S_PMUL;
        S_PMUL: begin
          if (alu_done) begin
            t0_r    <= lrf_pkg::word_t'(icpt_r) + alu_res - (lrf_pkg::word_t'(py) << 16);
            state_r <= S_PABS;
          end
        end
        S_PABS: begin
          e_r     <= t0_r[lrf_pkg::WORD_W-1] ? E_W'(~t0_r + 1'b1) : E_W'(t0_r);
          state_r <= S_PACC;
        end
        S_PACC: begin
          abs_r <= abs_r + AB_W'(e_r);
          // an error of 2^54 or more squares past the cap
          if (e_r[E_W-1:54] != '0) begin
            sse_r   <= SE_W'(SSE_CAP);
            state_r <= S_PNY;
          end else begin
            state_r <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (alu_done) begin
            sse_r   <= (sse_sum > SSE_CAP) ? SE_W'(SSE_CAP) : SE_W'(sse_sum);
            state_r <= S_PNY;
          end
        end
        S_PNY: begin
          if (alu_done) begin
            t1_r    <= alu_res - lrf_pkg::word_t'(sy_r);
            state_r <= S_PDV;
          end
        end
        S_PDV: begin
          if (alu_done) begin
            sst_r   <= sst_r + alu_res[ST_W-1:0];
            i_r     <= i_nxt;
            state_r <= (i_nxt == n_r) ? S_MAE : S_PRD;
          end
        end
        S_MAE: begin
          if (alu_done) begin
            mae_r   <= (alu_res > U47_MAX) ? U47_MAX[46:0] : alu_res[46:0];
            state_r <= S_MSE;
          end
        end
        S_MSE: begin
          if (alu_done) begin
            mse_r <= (alu_res > U63_MAX) ? U63_MAX[62:0] : alu_res[62:0];
            yc_r  <= (sst_r == '0);
            if (xc_r || sst_r == '0) begin
              r2_r    <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_RN1;
            end
          end
        end
        S_RN1: if (alu_done) begin t0_r <= alu_res; state_r <= S_RN2; end
        S_RN2: if (alu_done) begin t0_r <= alu_res; state_r <= S_RDIV; end
        S_RDIV: begin
          if (alu_done) begin
            r2_r    <= (alu_res >= R2_LIM) ? S48_MIN[47:0] : 48'(ONE_Q - alu_res);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output slot frees, then empty the set
          if (out_load) begin
            out_tdata_r <= {n_r[PC_W-1:0], r2_r,
                            xc_r ? 63'd0 : mse_r,
                            xc_r ? 47'd0 : mae_r,
                            xc_r ? 63'd0 : abs63,
                            icpt_r, slope_r};
            out_tuser_r <= {ovf_r, yc_r, xc_r};
            n_r     <= '0;
            sx_r    <= '0;
            sy_r    <= '0;
            sxx_r   <= '0;
            sxy_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> wait_r)
    else $error("arithmetic unit finished with no operation outstanding");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(lrf_pkg::MAX_POINTS))
    else $error("point count beyond store depth");

  a_no_wait_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD || state_r == S_DONE) |-> !wait_r)
    else $error("operation outstanding outside the fit");

  a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_tready)) |=>
      (out_tvalid && out_tdata[327:317] == $past(n_r[PC_W-1:0])))
    else $error("result word count differs from the set size");

  a_xc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[47:0] == '0 && out_tdata[95:48] == '0))
    else $error("constant x with a nonzero line");
`endif

endmodule
